### design/mm2_pkg.sv
package mm2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd5381;
    localparam int          QUEUE_DEPTH = 2;

    // one classified request handed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;     // clamped to 0..4
        logic        last;
        logic        first;
        logic [31:0] start;   // seed ^ key length, valid when first
    } t_work;

endpackage

### design/mm2_front.sv
module mm2_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    input  logic            i_push,
    input  logic            i_q_full,
    input  logic [31:0]     i_key_word,
    input  logic [2:0]      i_byte_count,
    input  logic            i_last_word,
    input  logic [15:0]     i_key_length,
    output logic            o_q_push,
    output mm2_pkg::t_work  o_q_data
);

    logic [31:0] r_seed;
    logic        r_inside;
    logic        accept;

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    always_comb begin
        o_q_data.word  = i_key_word;
        o_q_data.cnt   = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        o_q_data.last  = i_last_word;
        o_q_data.first = !r_inside;
        o_q_data.start = r_seed ^ {16'd0, i_key_length};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= mm2_pkg::SEED_RESET;
            r_inside <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (accept) begin
                r_inside <= !i_last_word;
            end
        end
    end

endmodule

### design/mm2_fifo.sv
module mm2_fifo #(
    parameter int DEPTH = mm2_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mm2_pkg::t_work  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output mm2_pkg::t_work  o_data,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mm2_pkg::t_work r_mem [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy above depth");

    ptrs_agree_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with pointers apart");

    count_tracks_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("count not incremented on push");

endmodule

### design/mm2_back.sv
module mm2_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  mm2_pkg::t_work  i_data,
    output logic            o_deq,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [31:0]     o_hash_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_H,
        S_TAIL,
        S_FIN,
        S_OUT
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_h;
    logic [31:0] n_h;
    logic [31:0] r_k;
    logic [31:0] n_k;
    logic [2:0]  r_cnt;
    logic        r_last;
    logic        r_out_valid;
    logic [31:0] r_out;
    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic [31:0] tail_mask;
    logic        out_free;

    assign o_deq        = (r_state == S_IDLE) && !i_empty;
    assign o_empty      = !r_out_valid;
    assign o_hash_value = r_out;
    assign out_free     = !r_out_valid || i_pop;

    always_comb begin
        case (r_cnt)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            3'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    // single shared constant multiplier
    always_comb begin
        case (r_state)
            S_K1:    mul_a = r_k;
            S_K2:    mul_a = r_k ^ (r_k >> mm2_pkg::MIX_SHIFT);
            S_H:     mul_a = r_h;
            S_TAIL:  mul_a = r_h ^ (r_k & tail_mask);
            S_FIN:   mul_a = r_h ^ (r_h >> mm2_pkg::FIN_SHIFT_A);
            default: mul_a = r_k;
        endcase
        mul_p = mul_a * mm2_pkg::MIX_MUL;
    end

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_h = i_data.first ? i_data.start : r_h;
                    n_k = i_data.word;
                    if (i_data.cnt == 3'd4) begin
                        n_state = S_K1;
                    end else if (i_data.last) begin
                        n_state = (i_data.cnt != 3'd0) ? S_TAIL : S_FIN;
                    end
                end
            end
            S_K1: begin
                n_k     = mul_p;
                n_state = S_K2;
            end
            S_K2: begin
                n_k     = mul_p;
                n_state = S_H;
            end
            S_H: begin
                n_h     = mul_p ^ r_k;
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_TAIL: begin
                n_h     = mul_p;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_h     = mul_p;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        r_k <= n_k;
        if (o_deq) begin
            r_cnt  <= i_data.cnt;
            r_last <= i_data.last;
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= r_h ^ (r_h >> mm2_pkg::FIN_SHIFT_B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    word_mix_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_K1) |=> (r_state == S_K2) ##1 (r_state == S_H))
        else $error("word mix sequence broken");

    result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result lost or changed");

    result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished hash not delivered");

    dequeue_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_deq |-> (r_state == S_IDLE && !i_empty))
        else $error("dequeue while busy");

endmodule

### design/murmur2_hash_engine.sv
// A request passes through the registered queue to the back end; a full word then
// steps through S_K1, S_K2 and S_H there, a tail fold through S_TAIL, and
// finalization through S_FIN and S_OUT before the result appears (empty low); an
// unpopped result holds the back end, which takes one request at a time (one multiplier).
// Reset (synchronous, active low): queues empty, no key open, seed = 5381.
module murmur2_hash_engine #(
    parameter int QUEUE_DEPTH = mm2_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic [15:0] i_key_length,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value
);

    mm2_pkg::t_work q_in;
    mm2_pkg::t_work q_out;
    logic           q_push;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    assign full = q_full;

    mm2_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .i_q_full     (q_full),
        .i_key_word   (i_key_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .i_key_length (i_key_length),
        .o_q_push     (q_push),
        .o_q_data     (q_in)
    );

    mm2_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    mm2_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_data       (q_out),
        .o_deq        (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_hash_value (o_hash_value)
    );

endmodule

### tb/tb_murmur2_hash_engine.sv
`timescale 1ns / 1ps

module tb_murmur2_hash_engine;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int PHASE_ITEMS    = 320;

    class hash_tracker;
        logic [31:0] hash_seed;
        logic [31:0] partial_hash;
        bit          in_key;
        logic [31:0] pending_hashes[$];
        int unsigned mismatches;

        function new();
            hash_seed    = mm2_pkg::SEED_RESET;
            partial_hash = '0;
            in_key       = 1'b0;
            mismatches   = 0;
        endfunction

        function logic [31:0] blend_word(logic [31:0] h, logic [31:0] k);
            k = k * mm2_pkg::MIX_MUL;
            k = k ^ (k >> mm2_pkg::MIX_SHIFT);
            k = k * mm2_pkg::MIX_MUL;
            h = h * mm2_pkg::MIX_MUL;
            return h ^ k;
        endfunction

        // published fall-through tail
        function logic [31:0] fold_tail_bytes(logic [31:0] h, logic [31:0] w,
                                              int unsigned n);
            if (n >= 3) h = h ^ {8'h00, w[23:16], 16'h0000};
            if (n >= 2) h = h ^ {16'h0000, w[15:8], 8'h00};
            if (n >= 1) begin
                h = h ^ {24'h000000, w[7:0]};
                h = h * mm2_pkg::MIX_MUL;
            end
            return h;
        endfunction

        function logic [31:0] finish_hash(logic [31:0] h);
            h = h ^ (h >> mm2_pkg::FIN_SHIFT_A);
            h = h * mm2_pkg::MIX_MUL;
            h = h ^ (h >> mm2_pkg::FIN_SHIFT_B);
            return h;
        endfunction

        function void note_request(logic [31:0] key_w, logic [2:0] cnt, logic last,
                                   logic [15:0] klen);
            logic [31:0] h;
            int unsigned n;
            n = (cnt > 3'd4) ? 4 : int'(cnt);
            if (!in_key) begin
                partial_hash = hash_seed ^ {16'h0000, klen};
                in_key = 1'b1;
            end
            h = partial_hash;
            if (n == 4) begin
                h = blend_word(h, key_w);
            end else if (last) begin
                h = fold_tail_bytes(h, key_w, n);
            end
            if (last) begin
                pending_hashes.push_back(finish_hash(h));
                partial_hash = '0;
                in_key = 1'b0;
            end else begin
                partial_hash = h;
            end
        endfunction

        function void check_hash(logic [31:0] actual);
            logic [31:0] want;
            if (pending_hashes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected hash %h", $realtime, actual);
            end else begin
                want = pending_hashes.pop_front();
                if (actual !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: hash_value expected %h actual %h",
                                 $realtime, want, actual);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        push;
    logic        full;
    logic [31:0] i_key_word;
    logic [2:0]  i_byte_count;
    logic        i_last_word;
    logic [15:0] i_key_length;
    logic        empty;
    logic        pop;
    logic [31:0] o_hash_value;

    hash_tracker tracker;
    int unsigned burst_left;
    int unsigned requests_sent;
    int unsigned rx_cycle;
    int unsigned idle_cycles;

    murmur2_hash_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_key_word  (i_key_word),
        .i_byte_count(i_byte_count),
        .i_last_word (i_last_word),
        .i_key_length(i_key_length),
        .empty       (empty),
        .pop         (pop),
        .o_hash_value(o_hash_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // called at a falling edge, returns at a falling edge
    task automatic push_request(input logic [31:0] key_w, input logic [2:0] cnt,
                                input logic last, input logic [15:0] klen);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                push <= 1'b0;
                @(negedge i_clk);
            end
        end
        burst_left--;
        push         <= 1'b1;
        i_key_word   <= key_w;
        i_byte_count <= cnt;
        i_last_word  <= last;
        i_key_length <= klen;
        do @(posedge i_clk); while (full);
        tracker.note_request(key_w, cnt, last, klen);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_key(input int unsigned nbytes, input logic [15:0] klen,
                            input bit empty_tail);
        int unsigned left;
        logic [2:0] cnt;
        bit fin;
        left = nbytes;
        do begin
            cnt = (left >= 4) ? 3'd4 : 3'(left);
            left -= int'(cnt);
            fin = (left == 0) && !(empty_tail && cnt == 3'd4);
            push_request($urandom, cnt, fin, klen);
        end while (!fin);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned goal;
        int unsigned len;
        logic [15:0] klen;
        goal = requests_sent + count;
        while (requests_sent < goal) begin
            if ($urandom_range(0, 99) < 85) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(0, 16);
                klen = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'(len);
                send_key(len, klen, $urandom_range(0, 2) == 0);
            end else begin
                push_request($urandom, 3'($urandom_range(0, 7)),
                             $urandom_range(0, 3) == 0, 16'($urandom));
            end
        end
        if (tracker.in_key)
            push_request($urandom, 3'($urandom_range(0, 4)), 1'b1, 16'($urandom));
        push <= 1'b0;
    endtask

    task automatic write_seed(input logic [31:0] seed);
        while (tracker.pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.hash_seed = seed;
    endtask

    // receiver stall pattern, cycling through four pop modes
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 128) % 4)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= (rx_cycle % 4) == 0;
            default: pop <= (rx_cycle % 12) == 0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            tracker.check_hash(o_hash_value);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] seeds[5];
        tracker       = new();
        burst_left    = 0;
        requests_sent = 0;
        rx_cycle      = 0;
        idle_cycles   = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        push          = 1'b0;
        pop           = 1'b0;
        i_key_word    = '0;
        i_byte_count  = '0;
        i_last_word   = 1'b0;
        i_key_length  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero-length key, single-item tails with junk in unused bytes, then one- and two-word keys
        push_request(32'h0000_0000, 3'd0, 1'b1, 16'h0000);
        push_request(32'hFFFF_FFFF, 3'd1, 1'b1, 16'h0001);
        push_request(32'hA5A5_00FF, 3'd2, 1'b1, 16'h0002);
        push_request(32'h5A12_3456, 3'd3, 1'b1, 16'h0003);
        push_request(32'hFFFF_FFFF, 3'd4, 1'b1, 16'h0004);
        push_request(32'h0000_0000, 3'd4, 1'b1, 16'h0004);
        push_request(32'h6172_6F66, 3'd4, 1'b0, 16'h0008);
        push_request(32'h7A61_6221, 3'd4, 1'b1, 16'h0008);
        // count above four acts as four
        push_request(32'h1234_5678, 3'd5, 1'b1, 16'hFFFF);
        push_request(32'h8765_4321, 3'd6, 1'b1, 16'hFFFF);
        push_request(32'hDEAD_BEEF, 3'd7, 1'b1, 16'hFFFF);
        // partial word that is not last is dropped
        push_request(32'hCAFE_F00D, 3'd2, 1'b0, 16'h0006);
        push_request(32'h0BAD_F00D, 3'd4, 1'b1, 16'h0006);
        // length disagrees with data
        push_request(32'h1111_1111, 3'd4, 1'b0, 16'hFFFF);
        push_request(32'h2222_2222, 3'd1, 1'b1, 16'hFFFF);
        // full word then an empty last request; full word, empty middle request, three-byte tail
        push_request(32'h3333_3333, 3'd4, 1'b0, 16'h0004);
        push_request(32'h4444_4444, 3'd0, 1'b1, 16'h0004);
        push_request(32'h5555_5555, 3'd7, 1'b0, 16'h000B);
        push_request(32'h6666_6666, 3'd0, 1'b0, 16'h000B);
        push_request(32'h0077_7777, 3'd3, 1'b1, 16'h000B);
        push <= 1'b0;

        run_random(PHASE_ITEMS);
        seeds[0] = 32'h0000_0000;
        seeds[1] = 32'hFFFF_FFFF;
        seeds[2] = $urandom;
        seeds[3] = $urandom;
        seeds[4] = $urandom;
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            run_random(PHASE_ITEMS);
        end

        while (tracker.pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
